### src/bmm_pkg.sv
// Package with shared constants and types for the bipartite matching core.
package bmm_pkg;

  localparam int unsigned MaxLeftDefault  = 128;
  localparam int unsigned MaxRightDefault = 128;
  localparam int unsigned CountWidth      = 8;
  localparam int unsigned IndexWidth      = 7;

  // Operation codes carried in the input word.
  localparam logic [1:0] OpAddEdge = 2'd0;
  localparam logic [1:0] OpRun     = 2'd1;
  localparam logic [1:0] OpClear   = 2'd2;

endpackage

### src/bipartite_max_matching_core.sv
// Top level of the bipartite maximum matching core (augmenting-path search).
//
//  channel   | dir | tdata fields (low to high)                     | extra
//  s_axis    | in  | op[1:0], left_index[8:2], right_index[15:9]   | -
//  m_axis    | out | match_count[7:0]                               | -
//  cfg       | in  | index 0 left_count, index 1 right_count        | write only
//
// An edge word reads its adjacency row, then writes it back.
// An ignored edge or an unused op is accepted and dropped in idle.
// A clear word sweeps the adjacency memory, one row a cycle;
// after reset the same sweep runs before the first word is taken.
// A run word clears the partner memory, then visits each root in turn; a search step
// reads the row, scans it and checks the partner, a backtrack reloads the stack top frame,
// and each vertex along a found path is rematched (read, then write); its duration depends on the graph.
// A finished count waits in the output register while m_axis_tready is low.
module bipartite_max_matching_core #(
  parameter int unsigned MAX_LEFT  = bmm_pkg::MaxLeftDefault,
  parameter int unsigned MAX_RIGHT = bmm_pkg::MaxRightDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // op[1:0], left_index[8:2], right_index[15:9]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // match_count[7:0]
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [7:0]  cfg_wdata_i
);
  import bmm_pkg::*;

  localparam int unsigned LW = (MAX_LEFT  > 1) ? $clog2(MAX_LEFT)  : 1;
  localparam int unsigned RW = (MAX_RIGHT > 1) ? $clog2(MAX_RIGHT) : 1;
  localparam int unsigned LC = $clog2(MAX_LEFT + 1);
  localparam int unsigned RC = $clog2(MAX_RIGHT + 1);
  localparam int unsigned IW = (LC > RC) ? LC : RC;
  localparam int unsigned SD = MAX_RIGHT + 1;
  localparam int unsigned SW = $clog2(SD);

  // State machine codes.
  localparam logic [3:0] StIdle   = 4'd0;
  localparam logic [3:0] StClrAdj = 4'd1;
  localparam logic [3:0] StEdgeWr = 4'd2;
  localparam logic [3:0] StClrPar = 4'd3;
  localparam logic [3:0] StRoot   = 4'd4;
  localparam logic [3:0] StRdTop  = 4'd5;
  localparam logic [3:0] StRdAdj  = 4'd6;
  localparam logic [3:0] StScan   = 4'd7;
  localparam logic [3:0] StChk    = 4'd8;
  localparam logic [3:0] StFlip   = 4'd9;
  localparam logic [3:0] StFlipWr = 4'd10;
  localparam logic [3:0] StOut    = 4'd11;

  // Memories: adjacency rows, right partners (with match flag), search stack.
  logic [MAX_RIGHT-1:0] adj_mem [MAX_LEFT];
  logic [LW:0]          par_mem [MAX_RIGHT];
  logic [LW+RC+RW-1:0]  stk_mem [SD];

  logic [3:0]            state_q, state_d;
  logic [CountWidth-1:0] lcnt_q, rcnt_q;
  logic [7:0]            out_q;
  logic                  out_vld_q;
  logic [IW-1:0]         idx_q;       // sweep index or root vertex
  logic [RW-1:0]         eidx_q;      // edge right index
  logic [MAX_RIGHT-1:0]  vis_q;
  logic [SW-1:0]         sp_q;
  logic [LW-1:0]         cur_l_q;
  logic [RC-1:0]         cur_n_q;
  logic [RW-1:0]         cur_r_q;
  logic [7:0]            total_q;

  logic [MAX_RIGHT-1:0] adj_rd_q;
  logic [LW:0]          par_rd_q;
  logic [LW+RC+RW-1:0]  stk_rd_q;

  // Effective counts, limited to the parameters.
  logic [LC-1:0] eff_l;
  logic [RC-1:0] eff_r;
  assign eff_l = ({24'd0, lcnt_q} > MAX_LEFT)  ? LC'(MAX_LEFT)  : LC'(lcnt_q);
  assign eff_r = ({24'd0, rcnt_q} > MAX_RIGHT) ? RC'(MAX_RIGHT) : RC'(rcnt_q);

  logic [1:0]            in_op;
  logic [IndexWidth-1:0] in_l, in_r;
  assign in_op = s_axis_tdata[1:0];
  assign in_l  = s_axis_tdata[8:2];
  assign in_r  = s_axis_tdata[15:9];

  assign s_axis_tready = (state_q == StIdle) && !out_vld_q;
  logic acc;
  assign acc = s_axis_tvalid && s_axis_tready;

  // First adjacent, unvisited, in-range right vertex at or above the resume point.
  logic [MAX_RIGHT-1:0] cand;
  logic                 found;
  logic [RW-1:0]        fidx;
  always_comb begin
    found = 1'b0;
    fidx  = '0;
    for (int i = 0; i < MAX_RIGHT; i++) begin
      cand[i] = adj_rd_q[i] && !vis_q[i] && (RC'(i) >= cur_n_q) && (RC'(i) < eff_r);
    end
    for (int i = MAX_RIGHT - 1; i >= 0; i--) begin
      if (cand[i]) begin
        found = 1'b1;
        fidx  = RW'(i);
      end
    end
  end

  // Memory port control.
  logic                 adj_we, par_we, stk_we;
  logic [LW-1:0]        adj_wa, adj_ra;
  logic [MAX_RIGHT-1:0] adj_wd;
  logic [RW-1:0]        par_wa, par_ra;
  logic [LW:0]          par_wd;
  logic [SW-1:0]        stk_wa, stk_ra;
  logic [LW+RC+RW-1:0]  stk_wd;

  logic [IW-1:0]  idx_d;
  logic [RW-1:0]  eidx_d;
  logic [MAX_RIGHT-1:0] vis_d;
  logic [SW-1:0]  sp_d;
  logic [LW-1:0]  cur_l_d;
  logic [RC-1:0]  cur_n_d;
  logic [RW-1:0]  cur_r_d;
  logic [7:0]     total_d;

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    eidx_d  = eidx_q;
    vis_d   = vis_q;
    sp_d    = sp_q;
    cur_l_d = cur_l_q;
    cur_n_d = cur_n_q;
    cur_r_d = cur_r_q;
    total_d = total_q;
    adj_we  = 1'b0;
    adj_wa  = idx_q[LW-1:0];
    adj_wd  = '0;
    adj_ra  = cur_l_q;
    par_we  = 1'b0;
    par_wa  = idx_q[RW-1:0];
    par_wd  = '0;
    par_ra  = fidx;
    stk_we  = 1'b0;
    stk_wa  = sp_q;
    stk_wd  = {cur_l_q, cur_n_q, cur_r_q};
    stk_ra  = sp_q;
    case (state_q)
      StIdle: begin
        if (acc) begin
          if (in_op == OpAddEdge) begin
            if (32'(in_l) < 32'(eff_l) && 32'(in_r) < 32'(eff_r)) begin
              adj_ra  = LW'(in_l);
              idx_d   = IW'(in_l);
              eidx_d  = RW'(in_r);
              state_d = StEdgeWr;
            end
          end else if (in_op == OpRun) begin
            idx_d   = '0;
            state_d = StClrPar;
          end else if (in_op == OpClear) begin
            idx_d   = '0;
            state_d = StClrAdj;
          end
        end
      end
      StClrAdj: begin
        adj_we = 1'b1;
        idx_d  = idx_q + 1'b1;
        if (idx_q == IW'(MAX_LEFT - 1)) state_d = StIdle;
      end
      StEdgeWr: begin
        adj_we = 1'b1;
        adj_wd = adj_rd_q | (MAX_RIGHT'(1) << eidx_q);
        state_d = StIdle;
      end
      StClrPar: begin
        par_we  = 1'b1;
        idx_d   = idx_q + 1'b1;
        total_d = '0;
        if (idx_q == IW'(MAX_RIGHT - 1)) begin
          idx_d   = '0;
          state_d = StRoot;
        end
      end
      StRoot: begin
        if (32'(idx_q) >= 32'(eff_l)) begin
          state_d = StOut;
        end else begin
          vis_d   = '0;
          sp_d    = '0;
          cur_l_d = idx_q[LW-1:0];
          cur_n_d = '0;
          state_d = StRdAdj;
        end
      end
      StRdTop: begin
        // Stack top frame, read in StScan, is now in stk_rd_q and is loaded here.
        state_d = StRdAdj;
        cur_l_d = stk_rd_q[LW+RC+RW-1:RC+RW];
        cur_n_d = stk_rd_q[RC+RW-1:RW];
        cur_r_d = stk_rd_q[RW-1:0];
      end
      StRdAdj: begin
        adj_ra  = cur_l_q;
        state_d = StScan;
      end
      StScan: begin
        if (!found) begin
          if (sp_q == '0) begin
            idx_d   = idx_q + 1'b1;
            state_d = StRoot;
          end else begin
            sp_d    = sp_q - 1'b1;
            stk_ra  = sp_q - 1'b1;
            state_d = StRdTop;
          end
        end else begin
          cur_n_d = RC'(fidx) + 1'b1;
          cur_r_d = fidx;
          vis_d   = vis_q | (MAX_RIGHT'(1) << fidx);
          par_ra  = fidx;
          state_d = StChk;
        end
      end
      StChk: begin
        // Save this frame with its resume point and chosen right vertex.
        stk_we = 1'b1;
        if (!par_rd_q[LW]) begin
          total_d = total_q + 1'b1;
          stk_ra  = sp_q;
          state_d = StFlip;
        end else if (32'(sp_q) + 1 >= SD) begin
          state_d = StRdAdj;
        end else begin
          sp_d    = sp_q + 1'b1;
          cur_l_d = par_rd_q[LW-1:0];
          cur_n_d = '0;
          state_d = StRdAdj;
        end
      end
      StFlip: begin
        stk_ra  = sp_q;
        state_d = StFlipWr;
      end
      StFlipWr: begin
        // Rematch each frame along the path, deepest first.
        par_we = 1'b1;
        par_wa = stk_rd_q[RW-1:0];
        par_wd = {1'b1, stk_rd_q[LW+RC+RW-1:RC+RW]};
        if (sp_q == '0) begin
          idx_d   = idx_q + 1'b1;
          state_d = StRoot;
        end else begin
          sp_d    = sp_q - 1'b1;
          state_d = StFlip;
        end
      end
      StOut: begin
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // Synchronous memories with registered reads.
  always_ff @(posedge clk_i) begin
    if (adj_we) adj_mem[adj_wa] <= adj_wd;
    adj_rd_q <= adj_mem[adj_ra];
    if (par_we) par_mem[par_wa] <= par_wd;
    par_rd_q <= par_mem[par_ra];
    if (stk_we) stk_mem[stk_wa] <= stk_wd;
    stk_rd_q <= stk_mem[stk_ra];
  end

  // Control and datapath registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StClrAdj;
      lcnt_q    <= '0;
      rcnt_q    <= '0;
      out_vld_q <= 1'b0;
      idx_q     <= '0;
      total_q   <= '0;
      sp_q      <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      total_q <= total_d;
      sp_q    <= sp_d;
      if (cfg_we_i) begin
        if (cfg_index_i) rcnt_q <= cfg_wdata_i;
        else             lcnt_q <= cfg_wdata_i;
      end
      if (state_q == StOut) out_vld_q <= 1'b1;
      else if (m_axis_tready) out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    eidx_q  <= eidx_d;
    vis_q   <= vis_d;
    cur_l_q <= cur_l_d;
    cur_n_q <= cur_n_d;
    cur_r_q <= cur_r_d;
    if (state_q == StOut) out_q <= total_q;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;
endmodule

### dv/tb_top.sv
// Self-checking testbench for the bipartite maximum matching core.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bmm_pkg::*;

  localparam int unsigned NL = 128;
  localparam int unsigned NR = 128;
  localparam int unsigned CfgLeft  = 0;
  localparam int unsigned CfgRight = 1;
  localparam logic [1:0] OpUnused = 2'd3;

  // Checks match counts against a software matcher in the same order they are produced.
  class match_scoreboard;
    bit adj [NL][NR];
    int unsigned lcnt, rcnt;
    logic [7:0] count_q[$];
    int unsigned mismatches, checked, runs;

    // Kuhn search with an explicit stack, one visited set per attempt.
    function bit try_augment(int unsigned root, int unsigned rc, ref int partner[NR],
                             ref bit seen[NR]);
      int unsigned st_l[NR+1], st_n[NR+1], st_r[NR+1];
      int sp;
      int unsigned v, r;
      bit hit;
      sp = 0; st_l[0] = root; st_n[0] = 0;
      while (sp >= 0) begin
        v = st_l[sp]; r = st_n[sp]; hit = 0;
        while (r < rc) begin
          if (adj[v][r] && !seen[r]) begin
            hit = 1;
            break;
          end
          r++;
        end
        if (!hit) begin
          sp--;
          continue;
        end
        st_n[sp] = r + 1; st_r[sp] = r; seen[r] = 1;
        if (partner[r] < 0) begin
          for (int k = sp; k >= 0; k--) partner[st_r[k]] = st_l[k];
          return 1;
        end
        if (sp + 1 >= NR + 1) continue;
        sp++; st_l[sp] = partner[r]; st_n[sp] = 0;
      end
      return 0;
    endfunction

    function void configure(int unsigned idx, logic [7:0] val);
      if (idx == CfgLeft) lcnt = val; else rcnt = val;
    endfunction

    function void note_word(logic [1:0] op, logic [6:0] li, logic [6:0] ri);
      int unsigned lc, rc, total;
      int partner[NR];
      bit seen[NR];
      lc = (lcnt > NL) ? NL : lcnt;
      rc = (rcnt > NR) ? NR : rcnt;
      case (op)
        OpAddEdge: begin
          if (li < lc && ri < rc) adj[li][ri] = 1;
        end
        OpRun: begin
          foreach (partner[i]) partner[i] = -1;
          total = 0;
          for (int unsigned v = 0; v < lc; v++) begin
            foreach (seen[i]) seen[i] = 0;
            if (try_augment(v, rc, partner, seen)) total++;
          end
          count_q = {count_q, total[7:0]};
          runs++;
        end
        OpClear: begin
          foreach (adj[i, j]) adj[i][j] = 0;
        end
        default: ;
      endcase
    endfunction

    function void check_count(logic [7:0] got);
      logic [7:0] want;
      checked++;
      if (count_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected match_count %0d", got);
        return;
      end
      want = count_q.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("match_count expected %0d got %0d", want, got);
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic s_axis_tvalid, s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic m_axis_tvalid, m_axis_tready;
  logic [7:0] m_axis_tdata;
  logic cfg_we_i, cfg_index_i;
  logic [7:0] cfg_wdata_i;

  match_scoreboard sb;
  int unsigned idle_pct = 28;
  bit hold_off = 0;
  int unsigned words_sent = 0;

  bipartite_max_matching_core dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .cfg_we_i, .cfg_index_i, .cfg_wdata_i
  );

  initial begin
    clk_i = 0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #200ms;
    $display("FAILURE");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off requested by the stimulus.
  initial begin
    m_axis_tready = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_count(m_axis_tdata);
      if (hold_off) begin
        m_axis_tready <= 0;
        repeat (3000) @(posedge clk_i);
        hold_off = 0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  // Sends one word, with a random gap ahead of it.
  task automatic send_word(logic [1:0] op, logic [6:0] li, logic [6:0] ri);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {ri, li, op};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_word(op, li, ri);
    words_sent++;
  endtask

  // Waits for all counts to drain, then for any clear sweep still in progress.
  task automatic drain();
    s_axis_tvalid <= 0;
    while (sb.count_q.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic write_reg(int unsigned idx, logic [7:0] val);
    cfg_we_i <= 1;
    cfg_index_i <= idx[0];
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 0;
    sb.configure(idx, val);
    @(posedge clk_i);
  endtask

  // One random graph: mostly edges inside the counts, some outside, occasional unused ops and runs, then a run.
  task automatic random_graph(int unsigned lc, int unsigned rc, int unsigned edges);
    int unsigned pick;
    for (int unsigned i = 0; i < edges; i++) begin
      pick = $urandom_range(99);
      if (pick < 85 && lc > 0 && rc > 0)
        send_word(OpAddEdge, 7'($urandom_range(lc - 1)), 7'($urandom_range(rc - 1)));
      else if (pick < 95) send_word(OpAddEdge, 7'($urandom), 7'($urandom));
      else if (pick < 98) send_word(OpUnused, 7'($urandom), 7'($urandom));
      else send_word(OpRun, 7'($urandom), 7'($urandom));
    end
    send_word(OpRun, 7'($urandom), 7'($urandom));
  endtask

  initial begin
    int unsigned lc, rc;
    sb = new();
    rst_ni = 0;
    s_axis_tvalid = 0;
    s_axis_tdata = '0;
    cfg_we_i = 0;
    cfg_index_i = 0;
    cfg_wdata_i = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1;
    repeat (2) @(posedge clk_i);

    // Directed: empty graph, zero counts, full-range edges, duplicates, clear, op 3.
    send_word(OpRun, 0, 0);
    send_word(OpAddEdge, 0, 0);
    send_word(OpRun, 7'h7f, 7'h7f);
    drain();
    write_reg(CfgLeft, 8'd128);
    write_reg(CfgRight, 8'd128);
    send_word(OpAddEdge, 0, 0);
    send_word(OpAddEdge, 0, 0);
    send_word(OpAddEdge, 7'd127, 7'd127);
    send_word(OpAddEdge, 1, 0);
    send_word(OpAddEdge, 1, 7'd127);
    send_word(OpAddEdge, 7'd127, 0);
    send_word(OpUnused, 7'h55, 7'h2a);
    send_word(OpRun, 7'h2a, 7'h55);
    drain();
    // Counts shrunk after loading: stored edges beyond them are skipped.
    write_reg(CfgLeft, 8'd1);
    write_reg(CfgRight, 8'd127);
    send_word(OpRun, 0, 0);
    drain();
    // Counts above the limit are clipped.
    write_reg(CfgLeft, 8'd255);
    write_reg(CfgRight, 8'd200);
    send_word(OpAddEdge, 7'd64, 7'd63);
    send_word(OpRun, 0, 0);
    send_word(OpClear, 7'h7f, 7'h7f);
    send_word(OpRun, 0, 0);
    drain();

    // Long receiver hold-off while runs keep arriving.
    write_reg(CfgLeft, 8'd4);
    write_reg(CfgRight, 8'd4);
    hold_off = 1;
    for (int i = 0; i < 8; i++) send_word(OpRun, 0, 0);
    drain();

    // Random phases; every seventh phase runs with no idling.
    for (int ph = 0; words_sent < 1600; ph++) begin
      idle_pct = (ph % 7 == 3) ? 0 : 28;
      case ($urandom_range(9))
        0: begin lc = 128; rc = 128; end
        1: begin lc = 0; rc = $urandom_range(16); end
        2: begin lc = $urandom_range(255); rc = $urandom_range(255); end
        default: begin lc = $urandom_range(1, 16); rc = $urandom_range(1, 16); end
      endcase
      write_reg(CfgLeft, 8'(lc));
      write_reg(CfgRight, 8'(rc));
      if ($urandom_range(2) == 0) send_word(OpClear, 7'($urandom), 7'($urandom));
      lc = (lc > 128) ? 128 : lc;
      rc = (rc > 128) ? 128 : rc;
      random_graph(lc, rc, $urandom_range(4, 40));
      if ($urandom_range(3) == 0) begin
        // Shrink the counts over the loaded graph and run again.
        drain();
        write_reg(CfgLeft, 8'($urandom_range(lc)));
        write_reg(CfgRight, 8'($urandom_range(rc)));
        send_word(OpRun, 0, 0);
      end
      drain();
    end
    idle_pct = 28;
    repeat (50) @(posedge clk_i);

    $display("Sent %0d words including %0d matching runs; checked %0d counts.",
             words_sent, sb.runs, sb.checked);
    $display("Covered extreme and clipped counts, shrunk counts, clears and unused op.");
    if (sb.mismatches == 0 && sb.count_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
